// ----- hdl/rssm_pkg.sv -----
package rssm_pkg;

	// profile codes
	localparam logic [1:0] MODE_EXP   = 2'd0;
	localparam logic [1:0] MODE_COS   = 2'd1;
	localparam logic [1:0] MODE_CUBIC = 2'd2;
	localparam logic [1:0] MODE_HERM  = 2'd3;

	// register indexes
	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_INNER = 2'd1;
	localparam logic [1:0] REG_OUTER = 2'd2;

	localparam logic [31:0] OUTER_RESET = 32'd1048576;
	localparam logic [16:0] ONE16       = 17'd65536;
	localparam logic [30:0] ONE30       = 31'd1073741824;
	localparam logic [28:0] EXP_M1_Q30  = 29'd395007542;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

	localparam int T_BITS    = 16;
	localparam int U_BITS    = 32;
	localparam int D_BITS    = 32;
	localparam int W_BITS    = 17;
	localparam int COS_TERMS = 5;
	localparam int EXP_TERMS = 14;
	localparam int EXP_MULS  = 23;

	// stage schedule
	localparam int ST_TDIV  = 1;
	localparam int ST_CDIV  = 1;
	localparam int ST_CUSQ  = ST_CDIV + U_BITS;
	localparam int ST_CUCB  = ST_CUSQ + 1;
	localparam int ST_TSET  = ST_TDIV + T_BITS;
	localparam int ST_HERM  = ST_TSET + 1;
	localparam int ST_DDIV  = ST_TSET + 1;
	localparam int ST_CTAY  = ST_TSET + 1;
	localparam int ST_CSQ   = ST_CTAY + 4 * COS_TERMS;
	localparam int ST_CFLIP = ST_CSQ + 1;
	localparam int ST_ESET  = ST_DDIV + D_BITS;
	localparam int ST_ETAY  = ST_ESET + 1;
	localparam int ST_EMUL  = ST_ETAY + 3 * EXP_TERMS;
	localparam int ST_SSET  = ST_EMUL + EXP_MULS;
	localparam int ST_SDIV  = ST_SSET + 1;
	localparam int ST_EFIN  = ST_SDIV + W_BITS;
	localparam int ST_SEL   = ST_EFIN + 1;
	localparam int ST_SCALE = ST_SEL + 1;
	localparam int NSTG     = ST_SCALE + 1;

	// floor(2^30 / k) for k = 1..14
	localparam logic [30:0] EXP_RECIP [EXP_TERMS] = '{
		31'd1073741824, 31'd536870912, 31'd357913941, 31'd268435456,
		31'd214748364, 31'd178956970, 31'd153391689, 31'd134217728,
		31'd119304647, 31'd107374182, 31'd97612893, 31'd89478485,
		31'd82595524, 31'd76695844
	};

	// sine series divisors 2k(2k+1) and floor(2^30 / divisor)
	localparam logic [6:0] COS_DIV [COS_TERMS] = '{7'd6, 7'd20, 7'd42, 7'd72, 7'd110};
	localparam logic [30:0] COS_RECIP [COS_TERMS] = '{
		31'd178956970, 31'd53687091, 31'd25565281, 31'd14913080, 31'd9761289
	};

	typedef struct packed {
		logic [31:0] r;
		logic [31:0] fv;
		logic [31:0] fm;
		logic        degen;
		logic        hard;
		logic        inlo;
		logic [31:0] td_rem;
		logic [31:0] td_den;
		logic [15:0] t;
		logic [31:0] cu_rem;
		logic [31:0] u;
		logic [31:0] cu_sq;
		logic [16:0] cw;
		logic        tz;
		logic        neg;
		logic [31:0] dd_rem;
		logic [31:0] dd_den;
		logic [31:0] d16;
		logic        big;
		logic [4:0]  whole;
		logic [29:0] f30;
		logic [29:0] e_y;
		logic [30:0] e_term;
		logic [30:0] e_sum;
		logic [60:0] e_prod;
		logic [31:0] sg_rem;
		logic [31:0] sg_den;
		logic [16:0] sg_lo;
		logic [16:0] sg_q;
		logic [16:0] ew;
		logic        flip;
		logic [29:0] cs_x;
		logic [29:0] cs_y;
		logic [29:0] cs_z;
		logic [29:0] cs_term;
		logic [29:0] cs_sum;
		logic [60:0] cs_prod;
		logic [16:0] cosw;
		logic [31:0] h_tt;
		logic [16:0] hw;
		logic [16:0] w;
		logic [31:0] mv;
		logic [31:0] mm;
	} item_t;

endpackage

// ----- hdl/radial_smooth_step_mask_top.sv -----
// throughput: one word per cycle while the output is not stalled; the longest path is one divider bit or one multiply
// a stalled output freezes the whole pipeline, the skid register takes one more word
// reset clears all valid bits and the skid valid flag, and sets the profile registers
// to exponential, inner radius zero and outer radius 1048576
module radial_smooth_step_mask_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] radius,
	input  logic [31:0] field_value,
	input  logic [31:0] field_momentum,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] masked_value,
	output logic [31:0] masked_momentum,
	output logic [16:0] mask_weight,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [1:0]  mode_q;
	logic [31:0] inner_q;
	logic [31:0] outer_q;

	logic        skid_vld_q;
	logic [31:0] skid_r_q;
	logic [31:0] skid_fv_q;
	logic [31:0] skid_fm_q;

	logic          en;
	logic          src_vld;
	rssm_pkg::item_t src;

	logic            vld_s  [1:rssm_pkg::NSTG];
	rssm_pkg::item_t pipe_s [1:rssm_pkg::NSTG];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= rssm_pkg::MODE_EXP;
			inner_q <= '0;
			outer_q <= rssm_pkg::OUTER_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				rssm_pkg::REG_MODE:  mode_q  <= cfg_data[1:0];
				rssm_pkg::REG_INNER: inner_q <= cfg_data;
				rssm_pkg::REG_OUTER: outer_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline moves together, the skid register decouples the input
	assign en       = !vld_s[rssm_pkg::NSTG] || out_ready;
	assign in_ready = !skid_vld_q;
	assign src_vld  = skid_vld_q || in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (en) begin
			skid_vld_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && in_valid && in_ready) begin
			skid_r_q  <= radius;
			skid_fv_q <= field_value;
			skid_fm_q <= field_momentum;
		end
	end

	always_comb begin
		src    = '0;
		src.r  = skid_vld_q ? skid_r_q  : radius;
		src.fv = skid_vld_q ? skid_fv_q : field_value;
		src.fm = skid_vld_q ? skid_fm_q : field_momentum;
	end

	for (genvar k = 0; k < rssm_pkg::NSTG; k++) begin : g_st
		localparam bit IN_CTAY = (k >= rssm_pkg::ST_CTAY) &&
			(k < rssm_pkg::ST_CTAY + 4 * rssm_pkg::COS_TERMS);
		localparam bit IN_ETAY = (k >= rssm_pkg::ST_ETAY) &&
			(k < rssm_pkg::ST_ETAY + 3 * rssm_pkg::EXP_TERMS);
		localparam int CJ = IN_CTAY ? (k - rssm_pkg::ST_CTAY) / 4 : 0;
		localparam int CP = IN_CTAY ? (k - rssm_pkg::ST_CTAY) % 4 : 0;
		localparam int EJ = IN_ETAY ? (k - rssm_pkg::ST_ETAY) / 3 : 0;
		localparam int EP = IN_ETAY ? (k - rssm_pkg::ST_ETAY) % 3 : 0;
		localparam int MJ = k - rssm_pkg::ST_EMUL;

		logic            cur_vld;
		rssm_pkg::item_t cur;
		rssm_pkg::item_t nx;

		if (k == 0) begin : g_head
			assign cur_vld = src_vld;
			assign cur     = src;
		end else begin : g_body
			assign cur_vld = vld_s[k];
			assign cur     = pipe_s[k];
		end

		always_comb begin : p_step
			logic [32:0]        rem2;
			logic               ge;
			logic [16:0]        num;
			logic [16:0]        tc;
			logic               fl;
			logic [33:0]        p34;
			logic [47:0]        p48;
			logic [49:0]        p50;
			logic [60:0]        p61;
			logic [64:0]        p65;
			logic [32:0]        c33;
			logic [30:0]        q0;
			logic [37:0]        rr;
			logic [31:0]        dv;
			logic [46:0]        dvd;
			logic signed [49:0] sa;
			logic signed [49:0] sb;
			logic signed [49:0] sp;
			rem2 = '0;
			ge   = 1'b0;
			num  = '0;
			tc   = '0;
			fl   = 1'b0;
			p34  = '0;
			p48  = '0;
			p50  = '0;
			p61  = '0;
			p65  = '0;
			c33  = '0;
			q0   = '0;
			rr   = '0;
			dv   = '0;
			dvd  = '0;
			sa   = '0;
			sb   = '0;
			sp   = '0;
			nx   = cur;

			if (k == 0) begin
				nx.degen  = outer_q <= inner_q;
				nx.hard   = cur.r >= outer_q;
				nx.inlo   = cur.r <= inner_q;
				nx.td_rem = cur.r - inner_q;
				nx.td_den = outer_q - inner_q;
				nx.t      = '0;
				nx.cu_rem = cur.r;
				nx.u      = '0;
			end

			// position within the transition band, one quotient bit a stage
			if (k >= rssm_pkg::ST_TDIV && k < rssm_pkg::ST_TDIV + rssm_pkg::T_BITS) begin
				rem2      = {cur.td_rem, 1'b0};
				ge        = rem2 >= {1'b0, cur.td_den};
				nx.td_rem = ge ? 32'(rem2 - {1'b0, cur.td_den}) : rem2[31:0];
				nx.t      = {cur.t[14:0], ge};
			end

			// r / outer in Q32 for the cubic profile
			if (k >= rssm_pkg::ST_CDIV && k < rssm_pkg::ST_CDIV + rssm_pkg::U_BITS) begin
				rem2      = {cur.cu_rem, 1'b0};
				ge        = rem2 >= {1'b0, outer_q};
				nx.cu_rem = ge ? 32'(rem2 - {1'b0, outer_q}) : rem2[31:0];
				nx.u      = {cur.u[30:0], ge};
			end

			if (k == rssm_pkg::ST_CUSQ) begin
				p65      = 65'(cur.u) * 65'(cur.u) + 65'h80000000;
				nx.cu_sq = p65[63:32];
			end

			if (k == rssm_pkg::ST_CUCB) begin
				p65   = 65'(cur.cu_sq) * 65'(cur.u) + 65'h80000000;
				c33   = 33'(p65[63:32]) + 33'd32768;
				nx.cw = c33[32:16];
			end

			if (k == rssm_pkg::ST_TSET) begin
				nx.tz     = cur.t == '0;
				nx.neg    = !cur.t[15];
				num       = cur.t[15] ? ({cur.t, 1'b0} - 17'd65536) :
					(17'd65536 - {cur.t, 1'b0});
				nx.dd_rem = 32'(num);
				p34       = 34'(cur.t) * (34'd65536 - 34'(cur.t));
				nx.dd_den = p34[31:0];
				nx.d16    = '0;
				fl        = cur.t[15] && (cur.t[14:0] != '0);
				nx.flip   = fl;
				tc        = fl ? (17'd65536 - 17'(cur.t)) : 17'(cur.t);
				p48       = 48'(tc) * 48'(rssm_pkg::HALF_PI_Q30) + 48'd32768;
				nx.cs_x    = p48[45:16];
				nx.cs_term = p48[45:16];
				nx.cs_sum  = p48[45:16];
				p34       = 34'(cur.t) * 34'(cur.t);
				nx.h_tt   = p34[31:0];
			end

			if (k == rssm_pkg::ST_HERM) begin
				p50   = 50'(cur.h_tt) * (50'd196608 - 50'({cur.t, 1'b0})) + 50'h80000000;
				nx.hw = p50[48:32];
			end

			// |d| = |2t-1| / (t(1-t)) in Q16
			if (k >= rssm_pkg::ST_DDIV && k < rssm_pkg::ST_DDIV + rssm_pkg::D_BITS) begin
				rem2      = {cur.dd_rem, 1'b0};
				ge        = rem2 >= {1'b0, cur.dd_den};
				nx.dd_rem = ge ? 32'(rem2 - {1'b0, cur.dd_den}) : rem2[31:0];
				nx.d16    = {cur.d16[30:0], ge};
			end

			// sine series, four stages a term
			if (IN_CTAY) begin
				case (CP)
					0: begin
						p61      = 61'(cur.cs_term) * 61'(cur.cs_x);
						nx.cs_y  = p61[59:30];
					end
					1: begin
						p61      = 61'(cur.cs_y) * 61'(cur.cs_x);
						nx.cs_z  = p61[59:30];
					end
					2: begin
						nx.cs_prod = 61'(cur.cs_z) * 61'(rssm_pkg::COS_RECIP[CJ]);
					end
					default: begin
						q0 = cur.cs_prod[60:30];
						rr = 38'(cur.cs_z) - 38'(q0) * 38'(rssm_pkg::COS_DIV[CJ]);
						if (rr >= 38'(rssm_pkg::COS_DIV[CJ])) begin
							q0 = q0 + 31'd1;
						end
						nx.cs_term = q0[29:0];
						nx.cs_sum  = (CJ % 2 == 0) ? (cur.cs_sum - q0[29:0]) :
							(cur.cs_sum + q0[29:0]);
					end
				endcase
			end

			if (k == rssm_pkg::ST_CSQ) begin
				p61     = 61'(cur.cs_sum) * 61'(cur.cs_sum) + 61'h80000000000;
				nx.cosw = p61[60:44];
			end

			if (k == rssm_pkg::ST_CFLIP) begin
				nx.cosw = cur.flip ? (rssm_pkg::ONE16 - cur.cosw) : cur.cosw;
			end

			if (k == rssm_pkg::ST_ESET) begin
				nx.big    = cur.d16[31:16] >= 16'd24;
				nx.whole  = cur.d16[20:16];
				nx.f30    = {cur.d16[15:0], 14'b0};
				nx.e_term = rssm_pkg::ONE30;
				nx.e_sum  = rssm_pkg::ONE30;
			end

			// exp(-frac) series, three stages a term
			if (IN_ETAY) begin
				case (EP)
					0: begin
						p61    = 61'(cur.e_term) * 61'(cur.f30);
						nx.e_y = p61[59:30];
					end
					1: begin
						nx.e_prod = 61'(cur.e_y) * 61'(rssm_pkg::EXP_RECIP[EJ]);
					end
					default: begin
						q0 = cur.e_prod[60:30];
						rr = 38'(cur.e_y) - 38'(q0) * 38'(EJ + 1);
						if (rr >= 38'(EJ + 1)) begin
							q0 = q0 + 31'd1;
						end
						nx.e_term = q0;
						nx.e_sum  = (EJ % 2 == 0) ? (cur.e_sum - q0) : (cur.e_sum + q0);
					end
				endcase
			end

			// one factor of e^-1 per whole unit
			if (k >= rssm_pkg::ST_EMUL && k < rssm_pkg::ST_EMUL + rssm_pkg::EXP_MULS) begin
				if (5'(MJ) < cur.whole) begin
					p61      = 61'(cur.e_sum) * 61'(rssm_pkg::EXP_M1_Q30) + 61'h20000000;
					nx.e_sum = p61[60:30];
				end
			end

			if (k == rssm_pkg::ST_SSET) begin
				dv        = cur.big ? 32'(rssm_pkg::ONE30) :
					(32'(rssm_pkg::ONE30) + 32'(cur.e_sum));
				dvd       = 47'h4000_0000_0000 + 47'(dv[31:1]);
				nx.sg_rem = 32'(dvd[46:17]);
				nx.sg_lo  = dvd[16:0];
				nx.sg_den = dv;
				nx.sg_q   = '0;
			end

			// sigmoid 2^46 / (2^30 + e), rounded
			if (k >= rssm_pkg::ST_SDIV && k < rssm_pkg::ST_SDIV + rssm_pkg::W_BITS) begin
				rem2      = {cur.sg_rem, cur.sg_lo[16]};
				ge        = rem2 >= {1'b0, cur.sg_den};
				nx.sg_rem = ge ? 32'(rem2 - {1'b0, cur.sg_den}) : rem2[31:0];
				nx.sg_lo  = {cur.sg_lo[15:0], 1'b0};
				nx.sg_q   = {cur.sg_q[15:0], ge};
			end

			if (k == rssm_pkg::ST_EFIN) begin
				nx.ew = cur.tz ? '0 : (cur.neg ? (rssm_pkg::ONE16 - cur.sg_q) : cur.sg_q);
			end

			if (k == rssm_pkg::ST_SEL) begin
				if (mode_q == rssm_pkg::MODE_CUBIC) begin
					nx.w = cur.hard ? rssm_pkg::ONE16 : cur.cw;
				end else if (cur.degen) begin
					nx.w = cur.hard ? rssm_pkg::ONE16 : '0;
				end else if (cur.inlo) begin
					nx.w = '0;
				end else if (cur.hard) begin
					nx.w = rssm_pkg::ONE16;
				end else begin
					case (mode_q)
						rssm_pkg::MODE_EXP:  nx.w = cur.ew;
						rssm_pkg::MODE_COS:  nx.w = cur.cosw;
						rssm_pkg::MODE_HERM: nx.w = cur.hw;
						default:             nx.w = cur.hw;
					endcase
				end
			end

			// round half up of v * w / 2^16
			if (k == rssm_pkg::ST_SCALE) begin
				sb    = $signed({33'b0, cur.w});
				sa    = $signed({{18{cur.fv[31]}}, cur.fv});
				sp    = sa * sb + 50'sd32768;
				nx.mv = sp[47:16];
				sa    = $signed({{18{cur.fm[31]}}, cur.fm});
				sp    = sa * sb + 50'sd32768;
				nx.mm = sp[47:16];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k + 1] <= 1'b0;
			end else if (en) begin
				vld_s[k + 1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pipe_s[k + 1] <= nx;
			end
		end
	end

	assign out_valid       = vld_s[rssm_pkg::NSTG];
	assign masked_value    = pipe_s[rssm_pkg::NSTG].mv;
	assign masked_momentum = pipe_s[rssm_pkg::NSTG].mm;
	assign mask_weight     = pipe_s[rssm_pkg::NSTG].w;

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mask_weight <= rssm_pkg::ONE16)
		else $error("mask weight above one");

	a_zero_weight: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && mask_weight == '0) |-> (masked_value == '0 && masked_momentum == '0))
		else $error("zero weight gave a nonzero product");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(mask_weight)))
		else $error("result changed while output stalled");

endmodule
